// ----- hdl/max_pool_2d_argmax_unit_assert.svh -----
// Assertion helpers for the max pooling unit.
// Both expect clk_i and rst_ni in scope.
`ifndef MAX_POOL_2D_ARGMAX_UNIT_ASSERT_SVH
`define MAX_POOL_2D_ARGMAX_UNIT_ASSERT_SVH

`define MPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define MPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/mpa_pkg.sv -----
`timescale 1ns / 1ps

package mpa_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_WINDOW  = 4;
  localparam int STEP_MAX    = 7;
  localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  localparam int VAL_W      = 16;
  localparam int IDX_W      = 32;
  localparam int KREG_W     = 3;
  localparam int DIM_W      = 7;
  localparam int WAIT_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_STEP   = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_WIDTH  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic              restart;
    logic              pix_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              plane_end;
    logic              scan_start;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_first;
    logic              rd_row_end;
    logic [SLOT_W-1:0] k_m1;
    logic [DIM_W-1:0]  w_eff;
    logic              load_out;
    logic              plane_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
    if (v == '0) return DIM_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [KREG_W-1:0] clamp_small(input logic [KREG_W-1:0] v,
                                                     input logic [KREG_W-1:0] hi);
    if (v == '0) return KREG_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

// ----- hdl/mpa_if.sv -----
`timescale 1ns / 1ps

interface mpa_pix_if;
  import mpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

interface mpa_res_if;
  import mpa_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] max_value;
  logic [IDX_W-1:0]        max_index;
  logic                    plane_done;
  modport source (output valid, output max_value, output max_index, output plane_done,
                  input ready);
  modport sink (input valid, input max_value, input max_index, input plane_done,
                output ready);
endinterface

// ----- hdl/mpa_ram.sv -----
`timescale 1ns / 1ps

module mpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/mpa_ctrl.sv -----
`timescale 1ns / 1ps

module mpa_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mpa_pkg::dp_status_t              status_i,
  output mpa_pkg::dp_cmd_t                 cmd_o
);
  import mpa_pkg::*;

  `include "max_pool_2d_argmax_unit_assert.svh"

  localparam int PD_W = DIM_W + 1;

  logic [KREG_W-1:0] win_q, win_d, step_q, step_d;
  logic [DIM_W-1:0]  height_q, height_d, width_q, width_d;
  logic [COL_W-1:0]  col_q, col_d, col0_q, col0_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d, sl_q, sl_d, si_q, si_d, sj_q, sj_d;
  logic [WAIT_W-1:0] cwait_q, cwait_d, rwait_q, rwait_d;
  logic              pdone_q, pdone_d;
  state_e            state_q, state_d;

  logic [KREG_W-1:0] k_eff, s_eff, k_new;
  logic [DIM_W-1:0]  h_eff, w_eff;
  logic [SLOT_W-1:0] k_m1, rslot_inc, sl_inc;
  logic [WAIT_W-1:0] s_m1, kn_m1, k_m1_w;
  logic              accept, win_hit, col_last, row_last, pdone;

  assign k_eff  = clamp_small(win_q, KREG_W'(MAX_WINDOW));
  assign s_eff  = clamp_small(step_q, KREG_W'(STEP_MAX));
  assign h_eff  = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
  assign w_eff  = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
  assign k_m1   = SLOT_W'(k_eff - KREG_W'(1));
  assign k_m1_w = WAIT_W'(k_eff - KREG_W'(1));
  assign s_m1   = WAIT_W'(s_eff - KREG_W'(1));

  // window size that applies right after this config write
  assign k_new = (cfg_reg_e'(cfg_idx_i) == REG_WINDOW) ?
                 clamp_small(cfg_data_i[KREG_W-1:0], KREG_W'(MAX_WINDOW)) : k_eff;
  assign kn_m1 = WAIT_W'(k_new - KREG_W'(1));

  assign rslot_inc = (KREG_W'(rslot_q) + KREG_W'(1) == k_eff) ? '0 : rslot_q + SLOT_W'(1);
  assign sl_inc    = (KREG_W'(sl_q) + KREG_W'(1) == k_eff) ? '0 : sl_q + SLOT_W'(1);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign win_hit    = (rwait_q == '0) && (cwait_q == '0);
  assign col_last   = (DIM_W'(col_q) == w_eff - DIM_W'(1));
  assign row_last   = (DIM_W'(row_q) == h_eff - DIM_W'(1));
  assign pdone      = (PD_W'(row_q) + PD_W'(1) + PD_W'(s_eff) > PD_W'(h_eff)) &&
                      (PD_W'(col_q) + PD_W'(1) + PD_W'(s_eff) > PD_W'(w_eff));

  always_comb begin
    win_d    = win_q;
    step_d   = step_q;
    height_d = height_q;
    width_d  = width_q;
    col_d    = col_q;
    row_d    = row_q;
    rslot_d  = rslot_q;
    cwait_d  = cwait_q;
    rwait_d  = rwait_q;
    col0_d   = col0_q;
    sl_d     = sl_q;
    si_d     = si_q;
    sj_d     = sj_q;
    pdone_d  = pdone_q;
    state_d  = state_q;

    cmd_o            = '0;
    cmd_o.k_m1       = k_m1;
    cmd_o.w_eff      = w_eff;
    cmd_o.plane_done = pdone_q;

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WINDOW: win_d    = cfg_data_i[KREG_W-1:0];
        REG_STEP:   step_d   = cfg_data_i[KREG_W-1:0];
        REG_HEIGHT: height_d = cfg_data_i[DIM_W-1:0];
        REG_WIDTH:  width_d  = cfg_data_i[DIM_W-1:0];
        default:    win_d    = win_q;
      endcase
      col_d         = '0;
      row_d         = '0;
      rslot_d       = '0;
      cwait_d       = kn_m1;
      rwait_d       = kn_m1;
      cmd_o.restart = 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cmd_o.pix_we  = 1'b1;
            cmd_o.wr_addr = {rslot_q, col_q};
            if (win_hit) begin
              cmd_o.scan_start = 1'b1;
              sl_d    = rslot_inc;
              col0_d  = col_q - COL_W'(k_m1);
              si_d    = '0;
              sj_d    = '0;
              pdone_d = pdone;
              state_d = S_SCAN;
            end
            if (col_last) begin
              col_d   = '0;
              cwait_d = k_m1_w;
              if (row_last) begin
                row_d           = '0;
                rslot_d         = '0;
                rwait_d         = k_m1_w;
                cmd_o.plane_end = 1'b1;
              end else begin
                row_d   = row_q + ROW_W'(1);
                rslot_d = rslot_inc;
                rwait_d = (rwait_q == '0) ? s_m1 : rwait_q - WAIT_W'(1);
              end
            end else begin
              col_d   = col_q + COL_W'(1);
              cwait_d = (cwait_q == '0) ? s_m1 : cwait_q - WAIT_W'(1);
            end
          end
        end
        S_SCAN: begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_addr    = {sl_q, col0_q + COL_W'(sj_q)};
          cmd_o.rd_first   = (si_q == '0) && (sj_q == '0);
          cmd_o.rd_row_end = (sj_q == k_m1);
          if (sj_q == k_m1) begin
            sj_d = '0;
            si_d = si_q + SLOT_W'(1);
            sl_d = sl_inc;
            if (si_q == k_m1) begin
              state_d = S_DRAIN;
            end
          end else begin
            sj_d = sj_q + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          state_d = S_EMIT;
        end
        S_EMIT: begin
          if (status_i.out_free) begin
            cmd_o.load_out = 1'b1;
            state_d        = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= KREG_W'(2);
      step_q   <= KREG_W'(2);
      height_q <= DIM_W'(64);
      width_q  <= DIM_W'(64);
      col_q    <= '0;
      row_q    <= '0;
      rslot_q  <= '0;
      cwait_q  <= WAIT_W'(1);
      rwait_q  <= WAIT_W'(1);
      si_q     <= '0;
      sj_q     <= '0;
      state_q  <= S_IDLE;
    end else begin
      win_q    <= win_d;
      step_q   <= step_d;
      height_q <= height_d;
      width_q  <= width_d;
      col_q    <= col_d;
      row_q    <= row_d;
      rslot_q  <= rslot_d;
      cwait_q  <= cwait_d;
      rwait_q  <= rwait_d;
      si_q     <= si_d;
      sj_q     <= sj_d;
      state_q  <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col0_q  <= col0_d;
    sl_q    <= sl_d;
    pdone_q <= pdone_d;
  end

  `MPA_ASSERT(a_hit_starts_scan, (accept && win_hit && !cfg_we_i) |=> (state_q == S_SCAN), "window hit did not start a scan")
  `MPA_ASSERT(a_emit_returns, (state_q == S_EMIT && status_i.out_free && !cfg_we_i) |=> (state_q == S_IDLE), "result load did not return to idle")
  `MPA_ASSERT_NEVER(a_rw_overlap, cmd_o.pix_we && cmd_o.rd_en, "store write during window scan")
  `MPA_ASSERT_NEVER(a_slot_range, KREG_W'(rslot_q) >= k_eff, "row slot beyond window size")

endmodule

// ----- hdl/mpa_datapath.sv -----
`timescale 1ns / 1ps

module mpa_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [mpa_pkg::VAL_W-1:0] pixel_value_i,
  input  mpa_pkg::dp_cmd_t                 cmd_i,
  output mpa_pkg::dp_status_t              status_o,
  mpa_res_if.source                        res_o
);
  import mpa_pkg::*;

  `include "max_pool_2d_argmax_unit_assert.svh"

  localparam int SPAN_W = SLOT_W + DIM_W;

  logic [VAL_W-1:0]        rdata;
  logic [IDX_W-1:0]        plane_base_q, gidx_q, scan_idx_q, cand_idx_q, best_idx_q, out_idx_q;
  logic signed [VAL_W-1:0] best_val_q, out_val_q;
  logic                    cmp_valid_q, cmp_first_q, out_valid_q, out_pd_q;
  logic [SPAN_W-1:0]       span;
  logic [IDX_W-1:0]        row_step;

  mpa_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pix_we),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (pixel_value_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  // (k-1) rows back from the current pixel, then (k-1) columns back
  assign span     = SPAN_W'(cmd_i.k_m1) * SPAN_W'(cmd_i.w_eff);
  assign row_step = IDX_W'(cmd_i.w_eff) - IDX_W'(cmd_i.k_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_base_q <= '0;
      gidx_q       <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_first_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        gidx_q <= plane_base_q;
      end else if (cmd_i.pix_we) begin
        gidx_q <= gidx_q + IDX_W'(1);
        if (cmd_i.plane_end) begin
          plane_base_q <= gidx_q + IDX_W'(1);
        end
      end
      cmp_valid_q <= cmd_i.rd_en;
      cmp_first_q <= cmd_i.rd_first;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_idx_q <= gidx_q - IDX_W'(span) - IDX_W'(cmd_i.k_m1);
    end else if (cmd_i.rd_en) begin
      scan_idx_q <= cmd_i.rd_row_end ? scan_idx_q + row_step : scan_idx_q + IDX_W'(1);
    end
    if (cmd_i.rd_en) begin
      cand_idx_q <= scan_idx_q;
    end
    // strict compare keeps the first pixel in scan order on ties
    if (cmp_valid_q && (cmp_first_q || ($signed(rdata) > best_val_q))) begin
      best_val_q <= rdata;
      best_idx_q <= cand_idx_q;
    end
    if (cmd_i.load_out) begin
      out_val_q <= best_val_q;
      out_idx_q <= best_idx_q;
      out_pd_q  <= cmd_i.plane_done;
    end
  end

  assign status_o.out_free = !out_valid_q || res_o.ready;

  assign res_o.valid      = out_valid_q;
  assign res_o.max_value  = out_val_q;
  assign res_o.max_index  = out_idx_q;
  assign res_o.plane_done = out_pd_q;

  `MPA_ASSERT_NEVER(a_no_overrun, cmd_i.load_out && out_valid_q && !res_o.ready, "result word overwritten before taken")

endmodule

// ----- hdl/max_pool_2d_argmax_unit.sv -----
`timescale 1ns / 1ps

// 2D max pooling with argmax over a raster stream of signed Q8.8 pixels. Each
// word on pix_i is stored in a line store of the last window_size rows; a pixel
// that closes a pooling window yields one word on res_o with the window maximum,
// the global flat index of its first occurrence and a last-window-of-plane flag.
// A pixel that closes a window blocks further input until the scan, which
// walks the window one pixel per cycle through the single store read port,
// is done and the previous result word has been taken. Writing any
// configuration register restarts the current plane; the global index
// carries on from the start of that plane.

module max_pool_2d_argmax_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mpa_pix_if.sink                        pix_i,
  mpa_res_if.source                      res_o
);
  import mpa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_value_i (pix_i.pixel_value),
    .cmd_i         (cmd),
    .status_o      (status),
    .res_o         (res_o)
  );

endmodule

// ----- test/max_pool_2d_argmax_unit_checker.sv -----
`timescale 1ns / 1ps

module max_pool_2d_argmax_unit_checker
  import mpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mpa_pix_if                    pix_mon,
  mpa_res_if                    res_mon,
  output int                    fail_count_o,
  output int                    pending_count_o,
  output int                    words_checked_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic [IDX_W-1:0]        max_index;
    logic                    plane_done;
  } pool_result_t;

  pool_result_t            expected_windows[$];
  logic signed [VAL_W-1:0] line_buf[STORE_DEPTH];
  logic [KREG_W-1:0]       win_reg, step_reg;
  logic [DIM_W-1:0]        height_reg, width_reg;
  int unsigned             row_pos, col_pos;
  logic [IDX_W-1:0]        plane_base;

  function automatic int unsigned bound(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic apply_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_WINDOW: win_reg = data[KREG_W-1:0];
      REG_STEP:   step_reg = data[KREG_W-1:0];
      REG_HEIGHT: height_reg = data[DIM_W-1:0];
      REG_WIDTH:  width_reg = data[DIM_W-1:0];
      default: ;
    endcase
    // any write restarts the plane, global base is kept
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic pool_window(input logic signed [VAL_W-1:0] px);
    int unsigned             k, s, h, w, r, c, r0, c0, x, y;
    logic signed [VAL_W-1:0] best, v;
    logic [IDX_W-1:0]        best_at;
    pool_result_t            want;
    k = bound(win_reg, MAX_WINDOW);
    s = bound(step_reg, STEP_MAX);
    h = bound(height_reg, MAX_HEIGHT);
    w = bound(width_reg, MAX_WIDTH);
    r = row_pos;
    c = col_pos;
    if (r >= h) r = 0;
    if (c >= w) c = 0;
    line_buf[(r % k) * MAX_WIDTH + c] = px;
    if (r + 1 >= k && c + 1 >= k && (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
      r0 = r + 1 - k;
      c0 = c + 1 - k;
      best = line_buf[(r0 % k) * MAX_WIDTH + c0];
      best_at = plane_base + IDX_W'(r0 * w + c0);
      for (x = r0; x <= r; x++) begin
        for (y = c0; y <= c; y++) begin
          v = line_buf[(x % k) * MAX_WIDTH + y];
          if (v > best) begin
            best = v;
            best_at = plane_base + IDX_W'(x * w + y);
          end
        end
      end
      want.max_value = best;
      want.max_index = best_at;
      want.plane_done = (r + 1 + s > h) && (c + 1 + s > w);
      expected_windows.push_back(want);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        plane_base = plane_base + IDX_W'(h * w);
      end
    end
    row_pos = r;
    col_pos = c;
  endtask

  task automatic check_word();
    pool_result_t want;
    if (expected_windows.size() == 0) begin
      $error("result word with nothing pending: max_value %0d max_index %0d plane_done %0b",
             res_mon.max_value, res_mon.max_index, res_mon.plane_done);
      fail_count_o++;
    end else begin
      want = expected_windows.pop_front();
      if (res_mon.max_value !== want.max_value) begin
        $error("max_value: expected %0d, got %0d", want.max_value, res_mon.max_value);
        fail_count_o++;
      end
      if (res_mon.max_index !== want.max_index) begin
        $error("max_index: expected %0d, got %0d", want.max_index, res_mon.max_index);
        fail_count_o++;
      end
      if (res_mon.plane_done !== want.plane_done) begin
        $error("plane_done: expected %0b, got %0b", want.plane_done, res_mon.plane_done);
        fail_count_o++;
      end
    end
    words_checked_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_windows.delete();
      win_reg = KREG_W'(2);
      step_reg = KREG_W'(2);
      height_reg = DIM_W'(64);
      width_reg = DIM_W'(64);
      row_pos = 0;
      col_pos = 0;
      plane_base = '0;
      fail_count_o = 0;
      words_checked_o = 0;
      pending_count_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) check_word();
      if (cfg_we_i) apply_write(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      if (pix_mon.valid && pix_mon.ready) pool_window(pix_mon.pixel_value);
      pending_count_o <= expected_windows.size();
    end
  end

endmodule

// ----- test/max_pool_2d_argmax_unit_test.sv -----
`timescale 1ns / 1ps

module max_pool_2d_argmax_unit_test;
  import mpa_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count, pending_count, words_checked;
  int                    pixels_sent, settings_used, ready_hold;
  bit                    calm;

  mpa_pix_if pix ();
  mpa_res_if res ();

  max_pool_2d_argmax_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  max_pool_2d_argmax_unit_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pix_mon         (pix),
    .res_mon         (res),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .words_checked_o (words_checked)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_pixel();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return VAL_W'($urandom);
    if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: return 16'sh8000;
        1: return 16'sh7fff;
        2: return 16'sh0000;
        default: return 16'shffff;
      endcase
    end
    return VAL_W'($signed($urandom_range(0, 6)) - 3);
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 4) != 0) return DIM_W'($urandom_range(1, 8));
    case ($urandom_range(0, 3))
      0: return DIM_W'(0);
      1: return DIM_W'(64);
      2: return DIM_W'(127);
      default: return DIM_W'($urandom_range(9, 63));
    endcase
  endfunction

  // random receiver stalls; calm phases keep ready high
  initial begin
    res.ready = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk_i);
      if (calm) begin
        res.ready = 1'b1;
      end else if (ready_hold > 0) begin
        ready_hold--;
      end else if (res.ready) begin
        ready_hold = pick_gap();
        if (ready_hold > 0) begin
          res.ready = 1'b0;
          ready_hold--;
        end
      end else begin
        res.ready = 1'b1;
        ready_hold = $urandom_range(0, 8);
      end
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] k, s, h, w);
    write_reg(REG_WINDOW, k);
    write_reg(REG_STEP, s);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    settings_used++;
  endtask

  task automatic send_pixel(input logic signed [VAL_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.pixel_value = v;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  task automatic drain_results();
    pix.valid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // a pixel that closes no window may still be in flight: allow the worst scan
  task automatic settle();
    drain_results();
    repeat (24) @(negedge clk_i);
  endtask

  task automatic send_list(input logic signed [VAL_W-1:0] vals[$]);
    foreach (vals[i]) send_pixel(vals[i]);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] k, s, h, w;
    int unsigned           area, n;
    bit                    pause_mid;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WINDOW;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.pixel_value = '0;
    calm = 1'b0;
    pixels_sent = 0;
    settings_used = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ties at the extremes: first occurrence wins
    configure(2, 2, 2, 2);
    send_list('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000,
                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    settle();
    // zero registers read as one
    configure(0, 0, 0, 2);
    send_list('{16'shffff, 16'sh0000});
    settle();
    // oversized window saturates and still exceeds the plane: no words
    configure(7, 7, 3, 127);
    repeat (5) send_pixel(rand_pixel());
    settle();
    // partial plane, then a write restarts it
    configure(3, 1, 3, 3);
    send_list('{16'sd100, 16'sd200, -16'sd7, 16'sd4});
    settle();
    write_reg(REG_WIDTH, 3);
    send_list('{16'sd1, 16'sd9, 16'sd9, 16'sd2, 16'sd9, 16'sd0, -16'sd5, 16'sd9, 16'sd3});
    settle();

    while (pixels_sent < 1150) begin
      k = ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                      : CFG_DATA_W'($urandom_range(1, 4));
      s = CFG_DATA_W'($urandom_range(0, 7));
      h = rand_dim();
      w = rand_dim();
      calm = ($urandom_range(0, 3) == 0);
      configure(k, s, h, w);
      area = ((h == 0) ? 1 : (h > 64) ? 64 : h) * ((w == 0) ? 1 : (w > 64) ? 64 : w);
      if (area <= 200) begin
        n = area * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) n = n - $urandom_range(0, area - 1);
      end else begin
        n = $urandom_range(40, 300);
      end
      pause_mid = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++) begin
        if (pause_mid && i == n / 2) drain_results();
        send_pixel(rand_pixel());
      end
      settle();
    end
    calm = 1'b0;

    $display("Sent %0d pixel words over %0d register settings, checked %0d result words",
             pixels_sent, settings_used, words_checked);
    $display("Settings spanned window and step 0..7 and plane edges 0..127");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d result words outstanding", pending_count);
    $display("Verification failed");
    $finish;
  end

endmodule
